[hdl/sfm_pkg.sv]
// ---------------------------------------------------------------------------
// sfm_pkg: shared definitions for the substring first-match search block
// Request types, configuration register map and sizing constants.
// ---------------------------------------------------------------------------
`default_nettype none

package sfm_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int MAX_NEEDLE_DEF  = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int REG_W      = 64;
  localparam int OFFSET_W   = 32;
  localparam int CFG_IDX_W  = 2;
  // Needle byte slots held by the two needle registers together.
  localparam int NEEDLE_SLOTS = (2 * REG_W) / BYTE_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd2;

  localparam logic [LEN_W-1:0] NEEDLE_LEN_RST = 5'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic                overflow;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] needle_len;
    logic [REG_W-1:0] needle_bytes_low;
    logic [REG_W-1:0] needle_bytes_high;
  } cfg_regs_t;

endpackage

`default_nettype wire

[hdl/sfm_front.sv]
// ---------------------------------------------------------------------------
// sfm_front: window, byte counter and parallel needle compare
// Takes one haystack byte per cycle and classifies it into a found result,
// a not-found result or no result at all.
// ---------------------------------------------------------------------------
`default_nettype none

module sfm_front #(
  parameter int MAX_NEEDLE  = sfm_pkg::MAX_NEEDLE_DEF,
  parameter int OFFSET_BITS = sfm_pkg::OFFSET_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfm_pkg::cfg_regs_t cfg,
  input  wire logic               item_valid,
  input  wire sfm_pkg::in_item_t  item,
  output logic                    res_valid,
  output sfm_pkg::out_item_t      res
);

  localparam int CNT_W = (OFFSET_BITS > sfm_pkg::OFFSET_W) ? sfm_pkg::OFFSET_W : OFFSET_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [sfm_pkg::LEN_W-1:0] MAX_LEN = sfm_pkg::LEN_W'(MAX_NEEDLE);
  localparam int SLOT_W = $clog2(sfm_pkg::NEEDLE_SLOTS);

  logic [sfm_pkg::BYTE_W-1:0] window_r   [MAX_NEEDLE];
  logic [sfm_pkg::BYTE_W-1:0] window_nxt [MAX_NEEDLE];
  logic [sfm_pkg::BYTE_W-1:0] needle     [sfm_pkg::NEEDLE_SLOTS];
  logic [CNT_W-1:0]           bytes_seen_r;
  logic                       match_rep_r;
  logic                       count_sat_r;

  logic [sfm_pkg::LEN_W-1:0]  len_eff;
  logic [sfm_pkg::LEN_W-1:0]  len_m1;
  logic [CNT_W-1:0]           len_m1_ext;
  logic                       sat_now;
  logic                       prefix_short;
  logic                       mismatch;
  logic                       hit;
  logic [CNT_W-1:0]           offset;

  // Needle bytes, byte i at bits 8i of the low/high register pair.
  always_comb begin
    for (int i = 0; i < sfm_pkg::NEEDLE_SLOTS; i++) begin
      if (i < sfm_pkg::NEEDLE_SLOTS / 2) begin
        needle[i] = cfg.needle_bytes_low[i*sfm_pkg::BYTE_W +: sfm_pkg::BYTE_W];
      end else begin
        needle[i] = cfg.needle_bytes_high[(i - sfm_pkg::NEEDLE_SLOTS / 2)*sfm_pkg::BYTE_W
                                          +: sfm_pkg::BYTE_W];
      end
    end
  end

  // Out-of-range lengths are clamped into 1..MAX_NEEDLE.
  always_comb begin
    if (cfg.needle_len == '0) begin
      len_eff = sfm_pkg::LEN_W'(1);
    end else if (cfg.needle_len > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = cfg.needle_len;
    end
  end

  assign len_m1     = len_eff - sfm_pkg::LEN_W'(1);
  assign len_m1_ext = CNT_W'(len_m1);

  always_comb begin
    window_nxt[0] = item.text_byte;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  // Window entry j (j bytes back) lines up with needle byte len-1-j.
  always_comb begin
    logic [sfm_pkg::LEN_W-1:0] nidx;
    mismatch = 1'b0;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      nidx = len_m1 - sfm_pkg::LEN_W'(j);
      if ((sfm_pkg::LEN_W'(j) < len_eff) && (window_nxt[j] != needle[nidx[SLOT_W-1:0]])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign sat_now      = count_sat_r | (bytes_seen_r == CNT_MAX);
  assign prefix_short = !sat_now && (bytes_seen_r < len_m1_ext);
  assign hit          = !prefix_short && !mismatch;
  assign offset       = (bytes_seen_r >= len_m1_ext) ? (bytes_seen_r - len_m1_ext) : '0;

  assign res_valid        = item_valid && !match_rep_r && (hit || item.is_last);
  assign res.found        = hit;
  assign res.match_offset = hit ? sfm_pkg::OFFSET_W'(offset) : '0;
  assign res.overflow     = sat_now;

  always_ff @(posedge clk) begin
    if (!rst_n || (item_valid && item.is_last)) begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        window_r[k] <= '0;
      end
      bytes_seen_r <= '0;
      match_rep_r  <= 1'b0;
      count_sat_r  <= 1'b0;
    end else if (item_valid && !match_rep_r) begin
      window_r     <= window_nxt;
      bytes_seen_r <= sat_now ? bytes_seen_r : bytes_seen_r + CNT_W'(1);
      count_sat_r  <= sat_now;
      match_rep_r  <= hit;
    end
  end

endmodule

`default_nettype wire

[hdl/sfm_queue.sv]
// ---------------------------------------------------------------------------
// sfm_queue: result queue between the compare front and the result port
// A small register queue; the head entry drives the result port.
// ---------------------------------------------------------------------------
`default_nettype none

module sfm_queue #(
  parameter int DEPTH = sfm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sfm_pkg::out_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output sfm_pkg::out_item_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  sfm_pkg::out_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/substring_first_match.sv]
// ---------------------------------------------------------------------------
// substring_first_match: streaming search for the first needle occurrence
// Searches a byte stream for a needle of up to MAX_NEEDLE bytes and reports
// found with the start offset once, or not-found at the last byte.
// ---------------------------------------------------------------------------
// Throughput: one haystack byte per cycle, sustained, as long as results are
//   popped; the compare of the whole window happens in the accepting cycle.
// Results: a byte's result is written into the result queue when the byte is
//   accepted, and reaches the head once the results ahead of it are popped.
// Reset: synchronous, active low; clears the search state, the result queue
//   and sets the needle length to 1 with an all-zero needle.
`default_nettype none

module substring_first_match #(
  parameter int MAX_NEEDLE  = sfm_pkg::MAX_NEEDLE_DEF,
  parameter int OFFSET_BITS = sfm_pkg::OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = sfm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Haystack byte requests.
  input  wire logic                            in_push,
  input  wire sfm_pkg::in_item_t               in_data,
  output logic                                 in_full,
  // Result requests.
  output logic                                 out_empty,
  output sfm_pkg::out_item_t                   out_data,
  input  wire logic                            out_pop,
  // Configuration writes.
  input  wire logic                            cfg_we,
  input  wire logic [sfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sfm_pkg::REG_W-1:0]       cfg_wdata
);

  sfm_pkg::cfg_regs_t cfg_r;
  sfm_pkg::out_item_t front_res;
  logic               front_res_valid;
  logic               item_acc;
  logic               q_full;

  // Configuration registers. Writes to an index past the register list are
  // dropped. The search uses these values directly, so a new needle takes
  // effect with the next compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.needle_len        <= sfm_pkg::NEEDLE_LEN_RST;
      cfg_r.needle_bytes_low  <= '0;
      cfg_r.needle_bytes_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfm_pkg::REG_NEEDLE_LEN:  cfg_r.needle_len        <= cfg_wdata[sfm_pkg::LEN_W-1:0];
        sfm_pkg::REG_NEEDLE_LOW:  cfg_r.needle_bytes_low  <= cfg_wdata;
        sfm_pkg::REG_NEEDLE_HIGH: cfg_r.needle_bytes_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A byte is taken whenever the result queue has room, whether or not it
  // turns out to produce a result. The queue decouples the compare front
  // from a stalled consumer.
  assign in_full  = q_full;
  assign item_acc = in_push && !in_full;

  sfm_front #(
    .MAX_NEEDLE  (MAX_NEEDLE),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_acc),
    .item       (in_data),
    .res_valid  (front_res_valid),
    .res        (front_res)
  );

  // Result queue; its head is the result port.
  sfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_res_valid),
    .push_item (front_res),
    .full      (q_full),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_data)
  );

endmodule

`default_nettype wire

[hdl/sfm_checker.sv]
// ---------------------------------------------------------------------------
// sfm_checker: port-level checks for the substring search block
// Watches the request ports over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module sfm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire sfm_pkg::out_item_t out_data
);

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // An empty result side means the input side has room.
  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty |-> !in_full)
    else $error("input full while no result waits");

  // Results only appear or vanish through an accepted byte or pop.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_push && !in_full) && !(out_pop && !out_empty)) |=> $stable(out_empty))
    else $error("result count changed without a request");

  // A not-found result carries a zero offset.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.found) |-> (out_data.match_offset == '0))
    else $error("not-found result with nonzero offset");

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed before pop");

endmodule

bind substring_first_match sfm_checker u_sfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
